[rtl/wff_pkg.sv]
`default_nettype none

package wff_pkg;

  localparam int unsigned AXIS_LOW  = 0;
  localparam int unsigned AXIS_HIGH = 65535;

  localparam bit          AXIS_SPAN_OK = (AXIS_HIGH > AXIS_LOW);
  localparam logic [15:0] AXIS_SPAN    = 16'(AXIS_HIGH - AXIS_LOW);
  localparam logic [17:0] AXIS_SUM     = 18'(AXIS_HIGH + AXIS_LOW);

  localparam logic [15:0] DEAD_ZONE_RST    = 16'd328;
  localparam logic [15:0] BRAKE_WINDOW_RST = 16'd3277;
  localparam logic [14:0] BRAKE_GAIN_RST   = 15'd16384;
  localparam logic [14:0] CENTER_TQ_RST    = 15'd16384;
  localparam logic [15:0] CENTER_DIST_RST  = 16'd16384;
  localparam logic [14:0] FLOOR_TQ_RST     = 15'd3277;
  localparam logic [14:0] TORQUE_LIM_RST   = 15'd32767;

  typedef enum logic [2:0] {
    CFG_DEAD_ZONE,
    CFG_BRAKE_WINDOW,
    CFG_BRAKE_GAIN,
    CFG_CENTER_MAX_TORQUE,
    CFG_CENTER_MAX_DISTANCE,
    CFG_FLOOR_TORQUE,
    CFG_TORQUE_LIMIT,
    CFG_CENTERING_ON
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_DIFF,
    ST_MUL,
    ST_RDIV,
    ST_FIN,
    ST_OUT
  } fsm_state_e;

  typedef enum logic [2:0] {
    TK_ZERO,
    TK_FULL,
    TK_BRAKE,
    TK_CAP,
    TK_RAMP
  } tq_kind_e;

  typedef struct packed {
    logic               target_valid;
    logic signed [15:0] goal_position;
    logic signed [15:0] goal_torque;
    logic               sample_valid;
    logic        [15:0] wheel_raw;
  } in_req_t;

  typedef struct packed {
    logic signed [15:0] drive_level;
    logic               envelope_on;
  } out_rsp_t;

endpackage

`default_nettype wire

[rtl/wff_mul.sv]
`default_nettype none

module wff_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] a_i,
  input  logic [14:0] b_i,
  output logic        done_o,
  output logic [30:0] prod_o
);

  logic        busy_q;
  logic        done_q;
  logic [3:0]  cnt_q;
  logic [15:0] a_q;
  logic [31:0] p_q;
  logic [16:0] sum;

  // One multiplier bit per cycle: add the multiplicand into the upper half, then shift right.
  assign sum = p_q[31:15] + (p_q[0] ? {1'b0, a_q} : 17'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 4'd0;
    end else begin
      done_q <= busy_q && (cnt_q == 4'd14);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 4'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd14) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= {17'd0, b_i};
    end else if (busy_q) begin
      p_q <= {1'b0, sum, p_q[14:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q[30:0];

endmodule

`default_nettype wire

[rtl/wff_div.sv]
`default_nettype none

module wff_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [15:0] quotient_o
);

  logic        busy_q;
  logic        done_q;
  logic [3:0]  cnt_q;
  logic        ovf_q;
  logic [15:0] dvs_q;
  logic [15:0] rem_q;
  logic [15:0] quo_q;
  logic [16:0] trial;
  logic [16:0] rest;
  logic        fits;

  // Restoring division, one quotient bit per cycle. A quotient that does not fit
  // in 16 bits saturates to all ones.
  assign trial = {rem_q, quo_q[15]};
  assign rest  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 4'd0;
    end else begin
      done_q <= busy_q && (cnt_q == 4'd15);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 4'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q <= divisor_i;
      rem_q <= dividend_i[31:16];
      quo_q <= dividend_i[15:0];
      ovf_q <= (dividend_i[31:16] >= divisor_i);
    end else if (busy_q) begin
      rem_q <= fits ? rest[15:0] : trial[15:0];
      quo_q <= {quo_q[14:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = ovf_q ? 16'hffff : quo_q;

endmodule

`default_nettype wire

[rtl/wheel_force_feedback_torque.sv]
`default_nettype none

// Wheel force-feedback torque. One request in gives one response out: the request
// may latch a new target (position and torque magnitude, taken only when it differs,
// which also clears the brake flag) and may carry a raw axis sample that is scaled
// to a signed Q1.15 wheel position. The response is a constant-force drive level,
// positively limited by torque_limit, and the envelope flag. A wheel sample is scaled
// in the shared bit-serial divider; the brake torque uses the bit-serial multiplier,
// and the centering ramp uses the multiplier and then the divider for its slope.
// Requests are worked one at a time: the next request is accepted as soon as the
// response sits in the output register.
module wheel_force_feedback_torque (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wff_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output wff_pkg::out_rsp_t out_rsp_o
);

  import wff_pkg::*;

  logic [15:0] dz_q;
  logic [15:0] bw_q;
  logic [14:0] bg_q;
  logic [14:0] cmt_q;
  logic [15:0] cmd_q;
  logic [14:0] flr_q;
  logic [14:0] lim_q;
  logic        con_q;

  fsm_state_e  state_q;
  fsm_state_e  state_d;

  logic [15:0] htp_q;
  logic [14:0] htt_q;
  logic [15:0] wp_q;
  logic        brk_q;

  tq_kind_e    kind_q;
  tq_kind_e    kind_d;
  logic        dir_q;
  logic        env_q;
  logic        rneg_q;
  logic        nneg_q;
  logic [15:0] torque_q;
  logic [15:0] torque_d;

  logic        out_valid_q;
  out_rsp_t    out_rsp_q;

  logic        accept;
  logic [15:0] gt_neg;
  logic [14:0] gt_mag;
  logic        tgt_new;
  logic [17:0] nx;
  logic [17:0] nx_neg;
  logic [16:0] nx_mag;

  logic [16:0] dff;
  logic [16:0] dff_neg;
  logic [15:0] adiff;
  logic        dir_pos;
  logic        centering;
  logic        env_d;
  logic        rneg;
  logic [14:0] rmag;

  logic        mul_start;
  logic [15:0] mul_a;
  logic [14:0] mul_b;
  logic        mul_done;
  logic [30:0] mul_prod;

  logic        div_start;
  logic [31:0] div_dividend;
  logic [15:0] div_divisor;
  logic        div_done;
  logic [15:0] div_quo;
  logic [15:0] pos_d;

  logic [17:0] qs;
  logic [17:0] bufv;
  logic [15:0] cl;
  logic [15:0] tv;
  logic [15:0] tlim;
  logic [15:0] lvl;

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q  <= DEAD_ZONE_RST;
      bw_q  <= BRAKE_WINDOW_RST;
      bg_q  <= BRAKE_GAIN_RST;
      cmt_q <= CENTER_TQ_RST;
      cmd_q <= CENTER_DIST_RST;
      flr_q <= FLOOR_TQ_RST;
      lim_q <= TORQUE_LIM_RST;
      con_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_DEAD_ZONE:           dz_q  <= cfg_data_i;
        CFG_BRAKE_WINDOW:        bw_q  <= cfg_data_i;
        CFG_BRAKE_GAIN:          bg_q  <= cfg_data_i[14:0];
        CFG_CENTER_MAX_TORQUE:   cmt_q <= cfg_data_i[14:0];
        CFG_CENTER_MAX_DISTANCE: cmd_q <= cfg_data_i;
        CFG_FLOOR_TORQUE:        flr_q <= cfg_data_i[14:0];
        CFG_TORQUE_LIMIT:        lim_q <= cfg_data_i[14:0];
        CFG_CENTERING_ON:        con_q <= cfg_data_i[0];
      endcase
    end
  end

  // Target magnitude saturates the most negative torque to full scale.
  always_comb begin
    gt_neg  = ~in_req_i.goal_torque + 16'd1;
    if (in_req_i.goal_torque[15]) begin
      gt_mag = (in_req_i.goal_torque == 16'sh8000) ? 15'h7fff : gt_neg[14:0];
    end else begin
      gt_mag = in_req_i.goal_torque[14:0];
    end
    tgt_new = (in_req_i.goal_position != htp_q) || (gt_mag != htt_q);
    nx      = {1'b0, in_req_i.wheel_raw, 1'b0} - AXIS_SUM;
    nx_neg  = ~nx + 18'd1;
    nx_mag  = nx[17] ? nx_neg[16:0] : nx[16:0];
  end

  always_comb begin
    dff       = {htp_q[15], htp_q} - {wp_q[15], wp_q};
    dff_neg   = ~dff + 17'd1;
    adiff     = dff[16] ? dff_neg[15:0] : dff[15:0];
    dir_pos   = !dff[16] && (dff != 17'd0);
    centering = brk_q || con_q;
    rneg      = (flr_q > cmt_q);
    rmag      = rneg ? (flr_q - cmt_q) : (cmt_q - flr_q);
    env_d     = 1'b0;
    if (centering) begin
      if (adiff < dz_q) begin
        kind_d = TK_ZERO;
      end else if (cmd_q <= dz_q) begin
        kind_d = TK_CAP;
      end else begin
        kind_d = TK_RAMP;
      end
    end else if (adiff < dz_q) begin
      kind_d = TK_ZERO;
    end else if (adiff < bw_q) begin
      kind_d = TK_BRAKE;
      env_d  = 1'b1;
    end else begin
      kind_d = TK_FULL;
      env_d  = 1'b1;
    end
    if (kind_d == TK_BRAKE) begin
      mul_a = {1'b0, htt_q};
      mul_b = bg_q;
    end else begin
      mul_a = adiff - dz_q;
      mul_b = rmag;
    end
  end

  always_comb begin
    if (state_q == ST_IDLE) begin
      div_dividend = {nx_mag, 15'd0};
      div_divisor  = AXIS_SPAN;
    end else begin
      div_dividend = {1'b0, mul_prod};
      div_divisor  = cmd_q - dz_q;
    end
    if (nneg_q) begin
      pos_d = div_quo[15] ? 16'h8000 : (~div_quo + 16'd1);
    end else begin
      pos_d = div_quo[15] ? 16'h7fff : div_quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_req_i.sample_valid && AXIS_SPAN_OK) begin
            div_start = 1'b1;
            state_d   = ST_NORM;
          end else begin
            state_d = ST_DIFF;
          end
        end
      end
      ST_NORM: begin
        if (div_done) begin
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        if (kind_d == TK_BRAKE || kind_d == TK_RAMP) begin
          mul_start = 1'b1;
          state_d   = ST_MUL;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          if (kind_q == TK_RAMP) begin
            div_start = 1'b1;
            state_d   = ST_RDIV;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_RDIV: begin
        if (div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      htp_q  <= 16'd0;
      htt_q  <= 15'd0;
      wp_q   <= 16'd0;
      brk_q  <= 1'b0;
      kind_q <= TK_ZERO;
    end else begin
      if (accept) begin
        if (in_req_i.target_valid && tgt_new) begin
          htp_q <= in_req_i.goal_position;
          htt_q <= gt_mag;
          brk_q <= 1'b0;
        end
        if (in_req_i.sample_valid && !AXIS_SPAN_OK) begin
          wp_q <= 16'd0;
        end
      end
      if (state_q == ST_NORM && div_done) begin
        wp_q <= pos_d;
      end
      if (state_q == ST_DIFF) begin
        kind_q <= kind_d;
        if (kind_d == TK_BRAKE) begin
          brk_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      nneg_q <= nx[17];
    end
    if (state_q == ST_DIFF) begin
      dir_q  <= dir_pos;
      env_q  <= env_d;
      rneg_q <= rneg;
    end
    if (state_q == ST_FIN) begin
      torque_q <= torque_d;
    end
  end

  // Torque by kind, turned toward the target; the centering ramp is floor plus the
  // signed slope term, clamped to the ceiling and to -32767.
  always_comb begin
    qs   = {2'b00, div_quo};
    bufv = rneg_q ? ({3'b000, flr_q} - qs) : ({3'b000, flr_q} + qs);
    if ($signed(bufv) > $signed({3'b000, cmt_q})) begin
      cl = {1'b0, cmt_q};
    end else if ($signed(bufv) < -18'sd32767) begin
      cl = 16'h8001;
    end else begin
      cl = bufv[15:0];
    end
    unique case (kind_q)
      TK_ZERO:  tv = 16'd0;
      TK_FULL:  tv = {1'b0, htt_q};
      TK_BRAKE: tv = 16'd0 - {1'b0, mul_prod[29:15]};
      TK_CAP:   tv = {1'b0, cmt_q};
      TK_RAMP:  tv = cl;
      default:  tv = 16'd0;
    endcase
    torque_d = dir_q ? tv : (16'd0 - tv);
  end

  // Scaling by 32767/32768 with truncation moves a nonzero torque one step toward zero.
  always_comb begin
    tlim = ($signed(torque_q) > $signed({1'b0, lim_q})) ? {1'b0, lim_q} : torque_q;
    if (tlim[15]) begin
      lvl = tlim + 16'd1;
    end else if (tlim != 16'd0) begin
      lvl = tlim - 16'd1;
    end else begin
      lvl = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
      out_rsp_q.drive_level <= lvl;
      out_rsp_q.envelope_on <= env_q;
    end
  end

  wff_mul u_wff_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  wff_div u_wff_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

[rtl/wff_checker.sv]
`default_nettype none

module wff_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input wff_pkg::out_rsp_t out_rsp_o
);

  import wff_pkg::*;

  // A response that is not taken stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("response changed while stalled");

  // The output scaling never reaches either full-scale code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.drive_level != 16'sh8000 &&
                     out_rsp_o.drive_level != 16'sh7fff))
    else $error("drive level out of range");

  // Requests are worked one at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while busy");

  // A new response only appears after a request has been in work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("response without request");

endmodule

bind wheel_force_feedback_torque wff_checker u_wff_checker (.*);

`default_nettype wire

[tb/sv/wheel_force_feedback_torque_test.sv]
`timescale 1ns / 100ps

module wheel_force_feedback_torque_test;
  import wff_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS = 200;

  class torque_book;
    int dead_zone, brake_window, brake_gain, center_torque, center_dist;
    int floor_tq, torque_limit;
    bit centering_on;
    int held_pos, held_tq, wheel_pos;
    bit braking;
    out_rsp_t levels_due[$];
    int errors;

    function new();
      dead_zone = DEAD_ZONE_RST;
      brake_window = BRAKE_WINDOW_RST;
      brake_gain = BRAKE_GAIN_RST;
      center_torque = CENTER_TQ_RST;
      center_dist = CENTER_DIST_RST;
      floor_tq = FLOOR_TQ_RST;
      torque_limit = TORQUE_LIM_RST;
      centering_on = 1'b0;
      held_pos = 0;
      held_tq = 0;
      wheel_pos = 0;
      braking = 1'b0;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [15:0] v);
      case (idx)
        CFG_DEAD_ZONE: dead_zone = v;
        CFG_BRAKE_WINDOW: brake_window = v;
        CFG_BRAKE_GAIN: brake_gain = v[14:0];
        CFG_CENTER_MAX_TORQUE: center_torque = v[14:0];
        CFG_CENTER_MAX_DISTANCE: center_dist = v;
        CFG_FLOOR_TORQUE: floor_tq = v[14:0];
        CFG_TORQUE_LIMIT: torque_limit = v[14:0];
        CFG_CENTERING_ON: centering_on = v[0];
        default: ;
      endcase
    endfunction

    function void take_request(in_req_t r);
      int gp, gt, diff, adiff, dir, tq;
      longint span, wide;
      bit env;
      out_rsp_t due;
      env = 1'b0;
      if (r.target_valid) begin
        gp = $signed(r.goal_position);
        gt = $signed(r.goal_torque);
        if (gt < 0) gt = -gt;
        if (gt > 32767) gt = 32767;
        if (gp != held_pos || gt != held_tq) begin
          held_pos = gp;
          held_tq = gt;
          braking = 1'b0;
        end
      end
      if (r.sample_valid) begin
        span = longint'(AXIS_HIGH) - longint'(AXIS_LOW);
        if (span <= 0) begin
          wheel_pos = 0;
        end else begin
          wide = (2 * longint'(r.wheel_raw) - (longint'(AXIS_HIGH) + longint'(AXIS_LOW)))
                 * 32768;
          wide = wide / span;
          if (wide > 32767) wide = 32767;
          if (wide < -32768) wide = -32768;
          wheel_pos = int'(wide);
        end
      end
      diff = held_pos - wheel_pos;
      adiff = diff < 0 ? -diff : diff;
      dir = diff > 0 ? 1 : -1;
      if (braking || centering_on) begin
        if (adiff < dead_zone) begin
          tq = 0;
        end else begin
          span = longint'(center_dist) - longint'(dead_zone);
          if (span <= 0) begin
            wide = center_torque;
          end else begin
            wide = longint'(floor_tq) + (longint'(adiff - dead_zone)
                   * longint'(center_torque - floor_tq)) / span;
          end
          if (wide > center_torque) wide = center_torque;
          if (wide < -32767) wide = -32767;
          tq = int'(wide) * dir;
        end
      end else if (adiff < dead_zone) begin
        tq = 0;
      end else if (adiff < brake_window) begin
        braking = 1'b1;
        tq = -((held_tq * brake_gain) >> 15) * dir;
        env = 1'b1;
      end else begin
        tq = held_tq * dir;
        env = 1'b1;
      end
      if (tq > torque_limit) tq = torque_limit;
      wide = (longint'(tq) * 32767) / 32768;
      due.drive_level = wide[15:0];
      due.envelope_on = env;
      levels_due.push_back(due);
    endfunction

    function void check_level(out_rsp_t got);
      out_rsp_t due;
      if (levels_due.size() == 0) begin
        $error("unexpected response: drive_level %0d envelope_on %0b",
               $signed(got.drive_level), got.envelope_on);
        errors++;
        return;
      end
      due = levels_due.pop_front();
      if (got.drive_level !== due.drive_level) begin
        $error("drive_level: expected %0d, actual %0d",
               $signed(due.drive_level), $signed(got.drive_level));
        errors++;
      end
      if (got.envelope_on !== due.envelope_on) begin
        $error("envelope_on: expected %0b, actual %0b", due.envelope_on, got.envelope_on);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_req_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_rsp_t out_rsp;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;
  torque_book book = new();

  wheel_force_feedback_torque uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .in_req_i(in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o(out_rsp)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (out_valid && out_ready) book.check_level(out_rsp);
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < QUIET_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("wheel_force_feedback_torque_test NOT OK");
      $finish;
    end
  end

  function automatic in_req_t make_request(bit tv, int gp, int gt, bit sv, int raw);
    in_req_t r;
    r.target_valid = tv;
    r.goal_position = 16'(gp);
    r.goal_torque = 16'(gt);
    r.sample_valid = sv;
    r.wheel_raw = 16'(raw);
    return r;
  endfunction

  // Samples are mostly aimed so that the wheel lands near the target or one
  // of the thresholds, measured from the target that will be held.
  function automatic in_req_t random_request();
    in_req_t r;
    int aim, off, base, raw;
    r.target_valid = ($urandom_range(99) < 25);
    r.sample_valid = ($urandom_range(99) < 80);
    r.goal_position = 16'($urandom);
    r.goal_torque = ($urandom_range(3) == 0) ? 16'(int'($urandom_range(800)) - 400)
                                             : 16'($urandom);
    if (r.target_valid && $urandom_range(99) < 15) begin
      r.goal_position = book.held_pos[15:0];
      r.goal_torque = $urandom_range(1) ? book.held_tq[15:0] : 16'(-book.held_tq);
      if (book.held_tq == 32767 && $urandom_range(1)) r.goal_torque = 16'h8000;
    end
    aim = r.target_valid ? int'($signed(r.goal_position)) : book.held_pos;
    case ($urandom_range(4))
      0: base = book.dead_zone;
      1: base = book.brake_window;
      2: base = book.center_dist;
      3: base = 0;
      default: base = -1;
    endcase
    if (base < 0) begin
      raw = $urandom_range(65535);
    end else begin
      off = base + int'($urandom_range(128)) - 64;
      if ($urandom_range(1)) off = -off;
      raw = aim - off + 32768;
      raw = raw < 0 ? 0 : (raw > 65535 ? 65535 : raw);
    end
    r.wheel_raw = raw[15:0];
    return r;
  endfunction

  task automatic send_request(in_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req <= r;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    book.take_request(r);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
    @(posedge clk_i);
    book.set_reg(idx, v);
  endtask

  task automatic apply_settings(int dz, int bw, int bg, int cmt, int cmd, int ft, int tl,
                                int co);
    logic [15:0] vals [8];
    vals = '{16'(dz), 16'(bw), 16'(bg), 16'(cmt), 16'(cmd), 16'(ft), 16'(tl), 16'(co)};
    in_valid <= 1'b0;
    while (book.levels_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    for (int i = 0; i < 8; i++) write_reg(cfg_reg_e'(i), vals[i]);
    cfg_we <= 1'b0;
  endtask

  initial begin
    in_req_t plan [$];
    int dz;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    plan.push_back(make_request(0, 0, 0, 0, 0));
    plan.push_back(make_request(1, 32767, -32768, 1, 0));
    plan.push_back(make_request(1, -32768, 32767, 1, 65535));
    plan.push_back(make_request(1, -32768, -32767, 0, 0));
    plan.push_back(make_request(0, 0, 0, 1, 1000));
    plan.push_back(make_request(0, 0, 0, 1, 500));
    plan.push_back(make_request(1, -32768, 32767, 1, 300));
    plan.push_back(make_request(0, 0, 0, 1, 0));
    plan.push_back(make_request(1, -32768, 32767, 1, 65535));
    plan.push_back(make_request(1, 0, 0, 1, 32768));
    plan.push_back(make_request(1, 12345, 20000, 0, 0));
    plan.push_back(make_request(1, 0, 32767, 1, 33000));
    plan.push_back(make_request(0, 0, 0, 1, 35000));
    plan.push_back(make_request(0, 0, 0, 1, 65535));
    plan.push_back(make_request(1, 100, -1, 1, 32768));
    plan.push_back(make_request(0, 0, 0, 1, 32367));
    foreach (plan[i]) send_request(plan[i]);

    apply_settings(328, 3277, 16384, 16384, 16384, 3277, 0, 1);
    send_request(make_request(1, 32767, 32767, 1, 0));
    send_request(make_request(1, -32768, 32767, 1, 65535));
    apply_settings(500, 3277, 16384, 10000, 200, 20000, 32767, 1);
    send_request(make_request(1, 0, 5, 1, 32000));
    send_request(make_request(1, 0, 5, 1, 32768));

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: apply_settings(0, 65535, 32767, 32767, 65535, 0, 32767, 0);
        1: apply_settings(65535, 0, 0, 0, 1, 32767, 0, 0);
        2: apply_settings(0, 200, 1000, 0, 1, 32767, 32767, 1);
        3: apply_settings(DEAD_ZONE_RST, BRAKE_WINDOW_RST, BRAKE_GAIN_RST, CENTER_TQ_RST,
                          CENTER_DIST_RST, FLOOR_TQ_RST, TORQUE_LIM_RST, 0);
        default: begin
          dz = $urandom_range(3000);
          apply_settings(dz, dz + int'($urandom_range(12000)), $urandom_range(32767),
                         $urandom_range(32767), $urandom_range(40000, 1),
                         $urandom_range(32767),
                         $urandom_range(1) ? 32767 : int'($urandom_range(32767)),
                         $urandom_range(2) == 0);
        end
      endcase
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 51;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 51;
        end
        default: begin
          send_idle_pct = 21;
          stall_pct = 21;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) send_request(random_request());
    end

    in_valid <= 1'b0;
    while (book.levels_due.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (book.errors == 0 && book.levels_due.size() == 0) begin
      $display("wheel_force_feedback_torque_test OK");
    end else begin
      $display("wheel_force_feedback_torque_test NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
rtl/wff_pkg.sv
rtl/wff_mul.sv
rtl/wff_div.sv
rtl/wheel_force_feedback_torque.sv
rtl/wff_checker.sv
tb/sv/wheel_force_feedback_torque_test.sv
